// ===== hw/rtl/tod_pkg.sv =====
// Shared types, codes and constants of the TCP option decoder.
package tod_pkg;

    // Byte position within one option list at which the list is forced to end.
    localparam int OPTION_BYTES_MAX = 40;
    localparam int CNT_W = $clog2(OPTION_BYTES_MAX + 1);

    // Option kind codes seen on the wire.
    localparam logic [7:0] OPT_MSS    = 8'd2;
    localparam logic [7:0] OPT_WSCALE = 8'd3;
    localparam logic [7:0] OPT_SACKOK = 8'd4;
    localparam logic [7:0] OPT_SACK   = 8'd5;
    localparam logic [7:0] OPT_TS     = 8'd8;

    // Decoded record kinds.
    localparam logic [3:0] REC_EOL       = 4'd0;
    localparam logic [3:0] REC_NOP       = 4'd1;
    localparam logic [3:0] REC_MSS       = 4'd2;
    localparam logic [3:0] REC_WSCALE    = 4'd3;
    localparam logic [3:0] REC_SACKOK    = 4'd4;
    localparam logic [3:0] REC_SACK      = 4'd5;
    localparam logic [3:0] REC_SACK_MALF = 4'd6;
    localparam logic [3:0] REC_TS        = 4'd7;
    localparam logic [3:0] REC_UNKNOWN   = 4'd8;
    localparam logic [3:0] REC_BAD       = 4'd9;

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic        list_done;
    } record_t;

endpackage

// ===== hw/rtl/tod_in_reg.sv =====
// Input register of the TCP option decoder.
module tod_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] option_byte
    input  logic              s_tlast,   // last_byte
    input  logic              advance,
    output logic              item_valid,
    output tod_pkg::in_item_t item
);
    import tod_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.option_byte <= s_tdata;
            item_reg.last_byte   <= s_tlast;
        end
    end

endmodule

// ===== hw/rtl/tod_parser.sv =====
// Option parse state and per-byte decode of the TCP option decoder.
module tod_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  tod_pkg::in_item_t item,
    output logic              rec_hit,
    output tod_pkg::record_t  rec
);
    import tod_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [7:0]       kind_reg, kind_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       body_reg, body_next;
    logic [31:0]      acc_a_reg, acc_a_next;
    logic [31:0]      acc_b_reg, acc_b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [CNT_W-1:0] cnt_inc;
    logic             ending;
    logic [2:0]       total_lo;
    logic             sack_ok;
    logic [7:0]       byte_in;

    assign byte_in = item.option_byte;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        left_next  = left_reg;
        body_next  = body_reg;
        acc_a_next = acc_a_reg;
        acc_b_next = acc_b_reg;
        rec_hit    = 1'b0;
        rec        = '0;
        total_lo   = body_reg[2:0] + left_reg[2:0];
        sack_ok    = (kind_reg == OPT_SACK) && (total_lo == 3'd0);

        cnt_inc = (cnt_reg < CNT_W'(OPTION_BYTES_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
        ending  = item.last_byte || (cnt_inc >= CNT_W'(OPTION_BYTES_MAX));

        unique case (phase_reg)
            PH_LEN:
            begin
                unique case (kind_reg)
                    OPT_MSS:
                    begin
                        left_next  = 8'd2;
                        phase_next = PH_BODY;
                    end
                    OPT_WSCALE:
                    begin
                        left_next  = 8'd1;
                        phase_next = PH_BODY;
                    end
                    OPT_SACKOK:
                    begin
                        rec_hit         = 1'b1;
                        rec.record_kind = REC_SACKOK;
                        phase_next      = PH_KIND;
                    end
                    OPT_TS:
                    begin
                        left_next  = 8'd8;
                        phase_next = PH_BODY;
                    end
                    default:
                    begin
                        // SACK and unknown kinds take their size from the length byte
                        if (byte_in < 8'd2)
                        begin
                            rec_hit         = 1'b1;
                            rec.record_kind = REC_BAD;
                            phase_next      = PH_DISCARD;
                        end
                        else if (byte_in == 8'd2)
                        begin
                            rec_hit         = 1'b1;
                            rec.record_kind = (kind_reg == OPT_SACK) ? REC_SACK_MALF
                                                                     : REC_UNKNOWN;
                            phase_next      = PH_KIND;
                        end
                        else
                        begin
                            left_next  = byte_in - 8'd2;
                            phase_next = PH_BODY;
                        end
                    end
                endcase
            end
            PH_BODY:
            begin
                if (kind_reg == OPT_MSS || kind_reg == OPT_WSCALE)
                begin
                    acc_a_next = {acc_a_reg[23:0], byte_in};
                end
                else if (kind_reg == OPT_TS)
                begin
                    if (body_reg < 8'd4)
                        acc_a_next = {acc_a_reg[23:0], byte_in};
                    else
                        acc_b_next = {acc_b_reg[23:0], byte_in};
                end
                else if (kind_reg == OPT_SACK)
                begin
                    if (body_reg[2] == 1'b0)
                        acc_a_next = {acc_a_reg[23:0], byte_in};
                    else
                        acc_b_next = {acc_b_reg[23:0], byte_in};
                end
                body_next = body_reg + 8'd1;
                if (left_reg != 8'd0)
                    left_next = left_reg - 8'd1;
                // Emit each SACK block as soon as its eighth byte lands
                if (sack_ok && body_next[2:0] == 3'd0)
                begin
                    rec_hit          = 1'b1;
                    rec.record_kind  = REC_SACK;
                    rec.first_value  = acc_a_next;
                    rec.second_value = acc_b_next;
                end
                if (left_next == 8'd0)
                begin
                    phase_next = PH_KIND;
                    if (kind_reg == OPT_MSS)
                    begin
                        rec_hit         = 1'b1;
                        rec.record_kind = REC_MSS;
                        rec.first_value = {16'd0, acc_a_next[15:0]};
                    end
                    else if (kind_reg == OPT_WSCALE)
                    begin
                        rec_hit         = 1'b1;
                        rec.record_kind = REC_WSCALE;
                        rec.first_value = {24'd0, acc_a_next[7:0]};
                    end
                    else if (kind_reg == OPT_TS)
                    begin
                        rec_hit          = 1'b1;
                        rec.record_kind  = REC_TS;
                        rec.first_value  = acc_a_next;
                        rec.second_value = acc_b_next;
                    end
                    else if (kind_reg == OPT_SACK)
                    begin
                        if (!sack_ok)
                        begin
                            rec_hit         = 1'b1;
                            rec.record_kind = REC_SACK_MALF;
                        end
                    end
                    else
                    begin
                        rec_hit         = 1'b1;
                        rec.record_kind = REC_UNKNOWN;
                    end
                end
            end
            PH_DISCARD:
            begin
                // drop bytes until the list ends
            end
            default:
            begin
                kind_next = byte_in;
                if (byte_in <= 8'd1)
                begin
                    rec_hit         = 1'b1;
                    rec.record_kind = byte_in[3:0];
                    phase_next      = PH_KIND;
                end
                else
                begin
                    phase_next = PH_LEN;
                    left_next  = 8'd0;
                    body_next  = 8'd0;
                    acc_a_next = 32'd0;
                    acc_b_next = 32'd0;
                end
            end
        endcase

        cnt_next = cnt_inc;
        if (ending)
        begin
            // An option still open at the end of the list is truncated
            if (phase_next == PH_LEN || phase_next == PH_BODY)
            begin
                rec_hit          = 1'b1;
                rec.record_kind  = REC_BAD;
                rec.first_value  = 32'd0;
                rec.second_value = 32'd0;
            end
            phase_next = PH_KIND;
            cnt_next   = '0;
        end
        rec.list_done = ending;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            kind_reg  <= 8'd0;
            left_reg  <= 8'd0;
            body_reg  <= 8'd0;
            acc_a_reg <= 32'd0;
            acc_b_reg <= 32'd0;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            left_reg  <= left_next;
            body_reg  <= body_next;
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(OPTION_BYTES_MAX))
        else $error("list byte count reached the forced end without clearing");

    a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != 8'd0)
        else $error("option body phase with no bytes left");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        take && ending |=> phase_reg == PH_KIND && cnt_reg == '0)
        else $error("parser did not return to kind phase after list end");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_hit && rec.record_kind == REC_BAD |->
            rec.first_value == 32'd0 && rec.second_value == 32'd0)
        else $error("bad record carries nonzero values");

    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DISCARD |-> !rec_hit)
        else $error("record produced while discarding");

endmodule

// ===== hw/rtl/tod_out_reg.sv =====
// Result register of the TCP option decoder.
module tod_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             rec_hit,
    input  tod_pkg::record_t rec,
    output logic             advance,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,  // [3:0] record_kind, [35:4] first_value,
                                       // [67:36] second_value, [71:68] zero
    output logic             m_tlast   // list_done
);
    import tod_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    record_t rec_reg;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? (load && rec_hit) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load && rec_hit)
        begin
            rec_reg <= rec;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, rec_reg.second_value, rec_reg.first_value, rec_reg.record_kind};
    assign m_tlast  = rec_reg.list_done;

endmodule

// ===== hw/rtl/tcp_option_decoder.sv =====
// TCP option decoder top level: input register, per-byte parser, result register.
//
//  channel  | dir | signals                          | item
//  ---------+-----+----------------------------------+------------------------------
//  s_*      | in  | tvalid tready tdata[7:0] tlast   | one option byte, last marks end
//  m_*      | out | tvalid tready tdata[71:0] tlast  | one decoded record, end of list
//
//  One byte is taken per cycle while the result register is not stalled; each byte
//  is held in the input register, and its record, if any, is loaded from there into
//  the result register, which drives m_tvalid. A record thus passes the input
//  register and then the result register before it can leave.
//  Reset (rst_n low, asynchronous) empties both registers and returns the parser
//  to expecting an option kind at the start of a list.
//  A stall on m_tready holds the result and the byte behind it; s_tready falls
//  only when both registers are occupied and m_tready is low.
module tcp_option_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] option_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] record_kind, [35:4] first_value,
                                   // [67:36] second_value, [71:68] zero
    output logic        m_tlast    // list_done
);
    import tod_pkg::*;

    logic     advance;
    logic     item_valid;
    in_item_t item;
    logic     take;
    logic     rec_hit;
    record_t  rec;

    assign take = item_valid && advance;

    tod_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tod_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (item),
        .rec_hit (rec_hit),
        .rec     (rec)
    );

    tod_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .rec_hit  (rec_hit),
        .rec      (rec),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/tcp_option_decoder_tb.sv =====
// Self-checking testbench for the TCP option decoder: directed lists, random lists, stalls.
module tcp_option_decoder_tb;
    import tod_pkg::*;

    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] LEN_MIN = 8'd2;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    // Decoder state as the predictor sees it
    phase_t      ph;
    logic [7:0]  cur_opt;
    logic [7:0]  remain;
    logic [7:0]  pos_cnt;
    logic [31:0] word_a;
    logic [31:0] word_b;
    int          list_pos;

    record_t     record_q[$];
    logic [7:0]  list_buf[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          cycle_cnt = 0;
    int          gap_max = 0;
    int          ready_max = 0;
    int          hold_req = 0;

    always #5 clk = ~clk;

    tcp_option_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    task automatic decode_option_byte(input logic [7:0] ob, input logic lb);
        record_t rec;
        logic    has_rec;
        logic    ending;
        logic    sack_ok;
        int      total;
        has_rec = 1'b0;
        rec = '0;
        if (list_pos < OPTION_BYTES_MAX)
            list_pos++;
        ending = lb || (list_pos >= OPTION_BYTES_MAX);
        case (ph)
            PH_LEN:
            begin
                case (cur_opt)
                    OPT_MSS:
                    begin
                        remain = 8'd2;
                        ph = PH_BODY;
                    end
                    OPT_WSCALE:
                    begin
                        remain = 8'd1;
                        ph = PH_BODY;
                    end
                    OPT_SACKOK:
                    begin
                        has_rec = 1'b1;
                        rec.record_kind = REC_SACKOK;
                        ph = PH_KIND;
                    end
                    OPT_TS:
                    begin
                        remain = 8'd8;
                        ph = PH_BODY;
                    end
                    default:
                    begin
                        if (ob < LEN_MIN)
                        begin
                            has_rec = 1'b1;
                            rec.record_kind = REC_BAD;
                            ph = PH_DISCARD;
                        end
                        else if (ob == LEN_MIN)
                        begin
                            has_rec = 1'b1;
                            rec.record_kind = (cur_opt == OPT_SACK) ? REC_SACK_MALF : REC_UNKNOWN;
                            ph = PH_KIND;
                        end
                        else
                        begin
                            remain = ob - LEN_MIN;
                            ph = PH_BODY;
                        end
                    end
                endcase
            end
            PH_BODY:
            begin
                total = int'(pos_cnt) + int'(remain);
                sack_ok = (cur_opt == OPT_SACK) && ((total % 8) == 0);
                if (cur_opt == OPT_MSS || cur_opt == OPT_WSCALE)
                    word_a = {word_a[23:0], ob};
                else if (cur_opt == OPT_TS)
                begin
                    if (pos_cnt < 8'd4)
                        word_a = {word_a[23:0], ob};
                    else
                        word_b = {word_b[23:0], ob};
                end
                else if (cur_opt == OPT_SACK)
                begin
                    if (pos_cnt[2:0] < 3'd4)
                        word_a = {word_a[23:0], ob};
                    else
                        word_b = {word_b[23:0], ob};
                end
                pos_cnt = pos_cnt + 8'd1;
                if (remain > 8'd0)
                    remain = remain - 8'd1;
                // a SACK block is complete every eighth body byte
                if (sack_ok && pos_cnt[2:0] == 3'd0)
                begin
                    has_rec = 1'b1;
                    rec.record_kind = REC_SACK;
                    rec.first_value = word_a;
                    rec.second_value = word_b;
                end
                if (remain == 8'd0)
                begin
                    ph = PH_KIND;
                    if (cur_opt == OPT_MSS)
                    begin
                        has_rec = 1'b1;
                        rec.record_kind = REC_MSS;
                        rec.first_value = {16'd0, word_a[15:0]};
                    end
                    else if (cur_opt == OPT_WSCALE)
                    begin
                        has_rec = 1'b1;
                        rec.record_kind = REC_WSCALE;
                        rec.first_value = {24'd0, word_a[7:0]};
                    end
                    else if (cur_opt == OPT_TS)
                    begin
                        has_rec = 1'b1;
                        rec.record_kind = REC_TS;
                        rec.first_value = word_a;
                        rec.second_value = word_b;
                    end
                    else if (cur_opt == OPT_SACK)
                    begin
                        if (!sack_ok)
                        begin
                            has_rec = 1'b1;
                            rec.record_kind = REC_SACK_MALF;
                        end
                    end
                    else
                    begin
                        has_rec = 1'b1;
                        rec.record_kind = REC_UNKNOWN;
                    end
                end
            end
            PH_DISCARD:
            begin
            end
            default:
            begin
                cur_opt = ob;
                if (ob == OPT_EOL || ob == OPT_NOP)
                begin
                    has_rec = 1'b1;
                    rec.record_kind = (ob == OPT_EOL) ? REC_EOL : REC_NOP;
                    ph = PH_KIND;
                end
                else
                begin
                    ph = PH_LEN;
                    remain = 8'd0;
                    pos_cnt = 8'd0;
                    word_a = 32'd0;
                    word_b = 32'd0;
                end
            end
        endcase
        if (ending)
        begin
            // an option still open at the end of the list is truncated
            if (ph == PH_LEN || ph == PH_BODY)
            begin
                has_rec = 1'b1;
                rec.record_kind = REC_BAD;
                rec.first_value = 32'd0;
                rec.second_value = 32'd0;
            end
            ph = PH_KIND;
            list_pos = 0;
        end
        rec.list_done = ending;
        if (has_rec)
            record_q.push_back(rec);
    endtask

    task automatic check_record(input logic [71:0] data, input logic done);
        record_t want;
        if (record_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: kind %0d first %h second %h done %b",
                         data[3:0], data[35:4], data[67:36], done);
        end
        else
        begin
            want = record_q.pop_front();
            if (data[3:0] !== want.record_kind || data[35:4] !== want.first_value ||
                data[67:36] !== want.second_value || done !== want.list_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record mismatch: exp kind %0d first %h second %h done %b,",
                             want.record_kind, want.first_value, want.second_value,
                             want.list_done,
                             " got kind %0d first %h second %h done %b",
                             data[3:0], data[35:4], data[67:36], done);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_record(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                decode_option_byte(s_tdata, s_tlast);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Record sink: random stalls, plus one long hold-off when requested
    initial
    begin : record_sink
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req = 0;
            end
            else
                n = (ready_max == 0) ? 0 : $urandom_range(0, ready_max);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] ob, input logic lb);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ob;
        s_tlast <= lb;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_list(input bit mark_last);
        int n;
        n = list_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(list_buf[i], mark_last && (i == n - 1));
    endtask

    // Pause input until every predicted record has come out
    task automatic wait_for_records();
        s_tvalid <= 1'b0;
        repeat (3) @(posedge clk);
        while (record_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_bytes(input int n);
        for (int i = 0; i < n; i++)
            list_buf.push_back(rand_byte());
    endtask

    // Fixed-size options mostly carry their proper length; the decoder ignores it
    task automatic add_len(input int n);
        if ($urandom_range(0, 4) == 0)
            list_buf.push_back(rand_byte());
        else
            list_buf.push_back(8'(n));
    endtask

    task automatic add_option();
        int         len;
        logic [7:0] k;
        case ($urandom_range(0, 9))
            0: list_buf.push_back(OPT_NOP);
            1: list_buf.push_back(OPT_EOL);
            2:
            begin
                list_buf.push_back(OPT_MSS);
                add_len(4);
                add_bytes(2);
            end
            3:
            begin
                list_buf.push_back(OPT_WSCALE);
                add_len(3);
                add_bytes(1);
            end
            4:
            begin
                list_buf.push_back(OPT_SACKOK);
                add_len(2);
            end
            5, 6:
            begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(0, 40);
                else
                    len = 2 + 8 * $urandom_range(0, 4);
                list_buf.push_back(OPT_SACK);
                list_buf.push_back(8'(len));
                if (len > 2)
                    add_bytes(len - 2);
            end
            7:
            begin
                list_buf.push_back(OPT_TS);
                add_len(10);
                add_bytes(8);
            end
            default:
            begin
                do
                    k = 8'($urandom_range(0, 255));
                while (k == OPT_EOL || k == OPT_NOP || k == OPT_MSS || k == OPT_WSCALE ||
                       k == OPT_SACKOK || k == OPT_SACK || k == OPT_TS);
                len = $urandom_range(0, 10);
                list_buf.push_back(k);
                list_buf.push_back(8'(len));
                if (len > 2)
                    add_bytes(len - 2);
            end
        endcase
    endtask

    task automatic test_fixed_options();
        gap_max = 9;
        ready_max = 9;
        list_buf = '{OPT_EOL, OPT_NOP, OPT_MSS, 8'd4, 8'hFF, 8'hFF,
                     OPT_WSCALE, 8'd3, 8'h0E, OPT_SACKOK, 8'd2,
                     OPT_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
        send_list(1'b1);
        wait_for_records();
    endtask

    task automatic test_sack_and_unknown();
        gap_max = 0;
        ready_max = 0;
        // one full block, an empty SACK, a short body, and a skipped unknown kind
        list_buf = '{OPT_SACK, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                     OPT_SACK, 8'd2, OPT_SACK, 8'd5, 8'hAA, 8'hBB, 8'hCC,
                     8'h22, 8'd4, 8'h11, 8'h22};
        send_list(1'b1);
        wait_for_records();
    endtask

    task automatic test_bad_length();
        gap_max = 3;
        ready_max = 3;
        // the byte that ends a discarded list yields nothing
        list_buf = '{OPT_SACK, 8'd1, 8'h77, 8'h88};
        send_list(1'b1);
        list_buf = '{8'h09, 8'd0};
        send_list(1'b1);
        wait_for_records();
    endtask

    task automatic test_truncation();
        gap_max = 2;
        ready_max = 5;
        // first block goes out, second completes on the final byte and is dropped
        list_buf = '{OPT_SACK, 8'd26};
        for (int i = 1; i <= 16; i++)
            list_buf.push_back(8'(i * 17));
        send_list(1'b1);
        wait_for_records();
    endtask

    task automatic test_backpressure_overlong();
        gap_max = 0;
        ready_max = 0;
        hold_req = HOLD_CYCLES;
        // an MSS opened at the forced end of an unmarked list is truncated
        list_buf = {};
        for (int i = 0; i < OPTION_BYTES_MAX - 2; i++)
            list_buf.push_back(OPT_NOP);
        list_buf.push_back(OPT_MSS);
        list_buf.push_back(8'd4);
        send_list(1'b0);
        list_buf = '{OPT_NOP};
        send_list(1'b1);
        wait_for_records();
    endtask

    task automatic test_random_lists();
        int         start;
        int         target;
        logic [7:0] junk;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            ready_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if ($urandom_range(0, 19) == 0)
                target = $urandom_range(OPTION_BYTES_MAX + 1, 60);
            else
                target = $urandom_range(1, OPTION_BYTES_MAX);
            list_buf = {};
            if ($urandom_range(0, 9) == 0)
                add_bytes(target);
            else
                while (list_buf.size() < target)
                    add_option();
            // cut the list; an option that straddles the cut is truncated
            while (list_buf.size() > target)
                junk = list_buf.pop_back();
            send_list($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 29) == 0)
                wait_for_records();
        end
        wait_for_records();
    endtask

    initial
    begin
        ph = PH_KIND;
        cur_opt = 8'd0;
        remain = 8'd0;
        pos_cnt = 8'd0;
        word_a = 32'd0;
        word_b = 32'd0;
        list_pos = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fixed_options();
        test_sack_and_unknown();
        test_bad_length();
        test_truncation();
        test_backpressure_overlong();
        test_random_lists();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && record_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tod_pkg.sv
hw/rtl/tod_in_reg.sv
hw/rtl/tod_parser.sv
hw/rtl/tod_out_reg.sv
hw/rtl/tcp_option_decoder.sv
bench/tcp_option_decoder_tb.sv
